// ===== src/c2jd_pkg.sv =====
// ============================================================================
// c2jd_pkg - shared types and constants for the calendar to Julian date core
// Beat payload types, calendar constants and small constant lookup tables.
// ============================================================================
package c2jd_pkg;

    typedef struct packed {
        logic [13:0] year_in;
        logic [3:0]  month_in;
        logic [4:0]  day_in;
        logic [4:0]  hour_in;
        logic [5:0]  minute_in;
        logic [5:0]  second_in;
    } req_t;

    typedef struct packed {
        logic [45:0] jd_scaled;
        logic        gregorian;
    } rsp_t;

    localparam logic [13:0] CUT_YEAR     = 14'd1582;
    localparam logic [3:0]  CUT_MONTH    = 4'd10;
    localparam logic [4:0]  CUT_DAY      = 5'd5;
    localparam logic [23:0] JD_BASE      = 24'd1721027;
    localparam logic [23:0] YEAR_DAYS    = 24'd367;
    localparam logic [17:0] HALF_DAY     = 18'd43200;
    localparam logic [17:0] DAY_SECS     = 18'd86400;
    localparam logic [16:0] HOUR_SECS    = 17'd3600;
    localparam logic [16:0] MIN_SECS     = 17'd60;
    localparam logic [2:0]  DEC_MIN      = 3'd3;
    localparam logic [2:0]  DEC_RESET    = 3'd3;
    // floor(y / 100) = (y * YEAR_DIV_M) >> YEAR_DIV_S for y below 2^14
    localparam logic [14:0] YEAR_DIV_M   = 15'd20972;
    localparam int          YEAR_DIV_S   = 21;
    // floor(w / 27) = (w * DIV27_M) >> DIV27_S for w below 2^29
    localparam logic [29:0] DIV27_M      = 30'd636291452;
    localparam int          DIV27_S      = 34;
    localparam logic [4:0]  DIV27        = 5'd27;
    // half of the residual divisor 432
    localparam logic [8:0]  HALF_RESID   = 9'd216;

    // floor(275 * month / 9)
    function automatic logic [8:0] month_term(input logic [3:0] m);
        logic [8:0] t;
        case (m)
            4'd0:    t = 9'd0;
            4'd1:    t = 9'd30;
            4'd2:    t = 9'd61;
            4'd3:    t = 9'd91;
            4'd4:    t = 9'd122;
            4'd5:    t = 9'd152;
            4'd6:    t = 9'd183;
            4'd7:    t = 9'd213;
            4'd8:    t = 9'd244;
            4'd9:    t = 9'd275;
            4'd10:   t = 9'd305;
            4'd11:   t = 9'd336;
            4'd12:   t = 9'd366;
            4'd13:   t = 9'd397;
            4'd14:   t = 9'd427;
            default: t = 9'd458;
        endcase
        return t;
    endfunction

    // 10^k for k in 3..7
    function automatic logic [23:0] pow10(input logic [2:0] k);
        logic [23:0] p;
        case (k)
            3'd4:    p = 24'd10000;
            3'd5:    p = 24'd100000;
            3'd6:    p = 24'd1000000;
            3'd7:    p = 24'd10000000;
            default: p = 24'd1000;
        endcase
        return p;
    endfunction

    // 10^k / 86400 reduced to scale5(k) / 432
    function automatic logic [16:0] scale5(input logic [2:0] k);
        logic [16:0] s;
        case (k)
            3'd4:    s = 17'd50;
            3'd5:    s = 17'd500;
            3'd6:    s = 17'd5000;
            3'd7:    s = 17'd50000;
            default: s = 17'd5;
        endcase
        return s;
    endfunction

endpackage

// ===== src/c2jd_if.sv =====
// ============================================================================
// c2jd_if - valid/ready stream channels of the calendar to Julian date core
// Request channel carries one timestamp, response channel one Julian date.
// ============================================================================
interface c2jd_req_if;
    logic          valid;
    logic          ready;
    c2jd_pkg::req_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface c2jd_rsp_if;
    logic          valid;
    logic          ready;
    c2jd_pkg::rsp_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== src/calendar_to_julian_date_core.sv =====
// ============================================================================
// calendar_to_julian_date_core - calendar date and time to scaled Julian date
// Six-stage pipeline producing round_half_even(JD * 10^k), exact integer math.
// ============================================================================
// Usage: the core takes one timestamp beat per cycle while the response
// side is not stalled and returns one result beat per timestamp, in order,
// through the six register stages. Each of the six register stages
// carries its own valid bit and only holds when the stage after it is full
// and held, so bubbles collapse and a stalled response does not block input
// until the whole pipeline is full. The decimals register (cfg_we/cfg_wdata)
// selects 3..7 fractional digits (0..2 act as 3) and should be written only
// while the pipeline is empty. Dates before 5 Oct 1582 use the Julian
// calendar; that date and later ones the Gregorian one. Fields are not
// range checked and the result wraps modulo 2^46.
module calendar_to_julian_date_core
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [2:0]           cfg_wdata,
    c2jd_req_if.sink             req,
    c2jd_rsp_if.source           rsp
);

    logic [2:0] decimals_reg;
    logic [2:0] k_next;

    // stage valids and advance enables
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg;
    logic en1, en2, en3, en4, en5, en6;

    // stage 1
    logic [2:0]  s1_k_reg,    s1_k_next;
    logic        s1_greg_reg, s1_greg_next;
    logic [22:0] s1_d0_reg,   s1_d0_next;
    logic [28:0] s1_yprod_reg, s1_yprod_next;
    logic [17:0] s1_u_reg,    s1_u_next;

    // stage 2
    logic [2:0]  s2_k_reg,    s2_k_next;
    logic        s2_greg_reg;
    logic [22:0] s2_dm1a_reg, s2_dm1a_next;
    logic [16:0] s2_up_reg,   s2_up_next;

    // stage 3
    logic        s3_greg_reg;
    logic [45:0] s3_hi_reg,   s3_hi_next;
    logic [32:0] s3_v_reg,    s3_v_next;

    // stage 4
    logic        s4_greg_reg;
    logic [45:0] s4_hi_reg;
    logic [28:0] s4_w_reg,    s4_w_next;
    logic [3:0]  s4_lo_reg,   s4_lo_next;
    logic [24:0] s4_qq_reg,   s4_qq_next;

    // stage 5
    logic        s5_greg_reg;
    logic [45:0] s5_sum_reg,  s5_sum_next;
    logic [8:0]  s5_rp_reg,   s5_rp_next;

    // output stage
    logic [45:0] jd_reg,      jd_next;
    logic        greg_reg;

    // ------------------------------------------------------------------
    // Flow control: a stage loads when it is empty or the next one loads
    // ------------------------------------------------------------------
    assign en6 = !v6_reg || rsp.ready;
    assign en5 = !v5_reg || en6;
    assign en4 = !v4_reg || en5;
    assign en3 = !v3_reg || en4;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;

    assign req.ready = en1;
    assign rsp.valid = v6_reg;
    assign rsp.data.jd_scaled = jd_reg;
    assign rsp.data.gregorian = greg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            decimals_reg <= c2jd_pkg::DEC_RESET;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                decimals_reg <= cfg_wdata;
            end
            if (en1) v1_reg <= req.valid;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
            if (en4) v4_reg <= v3_reg;
            if (en5) v5_reg <= v4_reg;
            if (en6) v6_reg <= v5_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: calendar rule, uncorrected day number, seconds of day
    // ------------------------------------------------------------------
    always_comb
    begin
        logic [13:0] y;
        logic [3:0]  mo;
        logic [4:0]  dy;
        logic [1:0]  c;
        logic [14:0] y_adj;
        logic [16:0] t7;
        logic [23:0] d0w;
        logic [13:0] yp;
        logic [16:0] secs;

        y  = req.data.year_in;
        mo = req.data.month_in;
        dy = req.data.day_in;

        k_next = (decimals_reg < c2jd_pkg::DEC_MIN) ? c2jd_pkg::DEC_MIN : decimals_reg;
        s1_k_next = k_next;

        s1_greg_next = !((y < c2jd_pkg::CUT_YEAR) ||
                         ((y == c2jd_pkg::CUT_YEAR) &&
                          ((mo < c2jd_pkg::CUT_MONTH) ||
                           ((mo == c2jd_pkg::CUT_MONTH) && (dy < c2jd_pkg::CUT_DAY)))));

        // floor((month + 9) / 12)
        c = (mo == 4'd15) ? 2'd2 : ((mo >= 4'd3) ? 2'd1 : 2'd0);
        y_adj = 15'(y) + 15'(c);
        t7 = 17'(y_adj) * 17'd7;
        d0w = 24'(y) * c2jd_pkg::YEAR_DAYS - 24'(t7 >> 2)
              + 24'(c2jd_pkg::month_term(mo)) + 24'(dy) + c2jd_pkg::JD_BASE;
        s1_d0_next = d0w[22:0];

        // year of the century rule; only used on the Gregorian side
        yp = (mo <= 4'd2) ? (y - 14'd1) : y;
        s1_yprod_next = 29'(yp) * 29'(c2jd_pkg::YEAR_DIV_M);

        secs = 17'(req.data.hour_in) * c2jd_pkg::HOUR_SECS
               + 17'(req.data.minute_in) * c2jd_pkg::MIN_SECS
               + 17'(req.data.second_in);
        s1_u_next = c2jd_pkg::HALF_DAY + 18'(secs);
    end

    // ------------------------------------------------------------------
    // Stage 2: century correction, fold whole days out of the time
    // ------------------------------------------------------------------
    always_comb
    begin
        logic [7:0]  cent;
        logic [8:0]  c3;
        logic [6:0]  corr;
        logic [22:0] d;
        logic        a;

        s2_k_next = s1_k_reg;
        cent = s1_yprod_reg[c2jd_pkg::YEAR_DIV_S +: 8];
        c3   = 9'(cent) * 9'd3 + 9'd3;
        corr = c3[8:2];
        d    = s1_greg_reg ? (s1_d0_reg + 23'd2 - 23'(corr)) : s1_d0_reg;

        a = (s1_u_reg >= c2jd_pkg::DAY_SECS);
        s2_up_next   = a ? 17'(s1_u_reg - c2jd_pkg::DAY_SECS) : s1_u_reg[16:0];
        s2_dm1a_next = d - 23'd1 + 23'(a);
    end

    // ------------------------------------------------------------------
    // Stage 3: scale whole days and the day fraction numerator
    // ------------------------------------------------------------------
    always_comb
    begin
        logic [46:0] hw;
        logic [33:0] vw;

        hw = 47'(s2_dm1a_reg) * 47'(c2jd_pkg::pow10(s2_k_reg));
        vw = 34'(s2_up_reg) * 34'(c2jd_pkg::scale5(s2_k_reg));
        s3_hi_next = hw[45:0];
        s3_v_next  = vw[32:0];
    end

    // ------------------------------------------------------------------
    // Stage 4: divide by 432 = 16 * 27, quotient of 27 by reciprocal
    // ------------------------------------------------------------------
    always_comb
    begin
        logic [58:0] pw;

        s4_w_next  = s3_v_reg[32:4];
        s4_lo_next = s3_v_reg[3:0];
        pw = 59'(s4_w_next) * 59'(c2jd_pkg::DIV27_M);
        s4_qq_next = pw[c2jd_pkg::DIV27_S +: 25];
    end

    // ------------------------------------------------------------------
    // Stage 5: residual and unrounded sum
    // ------------------------------------------------------------------
    always_comb
    begin
        logic [28:0] back;
        logic [28:0] rem;

        back = 29'(s4_qq_reg) * 29'(c2jd_pkg::DIV27);
        rem  = s4_w_reg - back;
        s5_rp_next  = {rem[4:0], s4_lo_reg};
        s5_sum_next = s4_hi_reg + 46'(s4_qq_reg);
    end

    // ------------------------------------------------------------------
    // Stage 6: round half to even
    // ------------------------------------------------------------------
    always_comb
    begin
        logic up;

        up = (s5_rp_reg > c2jd_pkg::HALF_RESID) ||
             ((s5_rp_reg == c2jd_pkg::HALF_RESID) && s5_sum_reg[0]);
        jd_next = s5_sum_reg + 46'(up);
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            s1_k_reg     <= s1_k_next;
            s1_greg_reg  <= s1_greg_next;
            s1_d0_reg    <= s1_d0_next;
            s1_yprod_reg <= s1_yprod_next;
            s1_u_reg     <= s1_u_next;
        end
        if (en2)
        begin
            s2_k_reg    <= s2_k_next;
            s2_greg_reg <= s1_greg_reg;
            s2_dm1a_reg <= s2_dm1a_next;
            s2_up_reg   <= s2_up_next;
        end
        if (en3)
        begin
            s3_greg_reg <= s2_greg_reg;
            s3_hi_reg   <= s3_hi_next;
            s3_v_reg    <= s3_v_next;
        end
        if (en4)
        begin
            s4_greg_reg <= s3_greg_reg;
            s4_hi_reg   <= s3_hi_reg;
            s4_w_reg    <= s4_w_next;
            s4_lo_reg   <= s4_lo_next;
            s4_qq_reg   <= s4_qq_next;
        end
        if (en5)
        begin
            s5_greg_reg <= s4_greg_reg;
            s5_sum_reg  <= s5_sum_next;
            s5_rp_reg   <= s5_rp_next;
        end
        if (en6)
        begin
            greg_reg <= s5_greg_reg;
            jd_reg   <= jd_next;
        end
    end

endmodule
